// File: rtl/bounded_deque_with_search_defines.svh
// Assertion macros used by the deque top level.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BDQS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BDQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bdqs_pkg.sv
// Shared types and constants for the bounded deque with search.
`default_nettype none

package bdqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int REQ_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // a request transfer happens this cycle
        logic step;    // advance the search walk by one entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_search;    // the offered request is a search
        logic empty;        // no entries held
        logic search_done;  // the search result is known this cycle
        logic out_free;     // the result register can take a new result
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/bounded_deque_with_search.sv
// Top level of the bounded double-ended queue with membership search.
`default_nettype none

// The block keeps an ordered sequence of up to DEPTH signed 32-bit values in a
// ring memory and answers one request per input transfer with exactly one result
// transfer. The request kind travels on s_axis_tuser (0 push front, 1 push back,
// 2 pop front, 3 pop back, 4 search; codes 5 to 7 do nothing and report done) and
// the value on s_axis_tdata. Each result carries a status (0 done, 1 push refused
// because the sequence is full, 2 pop ignored because it is empty), a found flag
// that only a successful search sets, and the occupancy after the request.
// Pushes, pops, unused codes and a search of an empty sequence answer without a walk:
// the result is registered in the cycle after the request transfer. A search of
// a sequence holding N entries walks them from front to back through the single
// registered read port of the ring memory, one entry per cycle, and stops at the
// first match. The block works on one request at a time. It takes the next
// request while the previous result waits only in the cycle that result is
// taken, so s_axis_tready follows m_axis_tready combinationally while a result
// is pending. The memory needs no clearing after reset: the sequence starts
// empty and only held entries are ever read.
module bounded_deque_with_search #(
    parameter  int DEPTH      = bdqs_pkg::DEPTH_DEF,
    localparam int OCC_W      = $clog2(DEPTH + 1),
    localparam int OUT_DATA_W = ((bdqs_pkg::STATUS_W + 1 + OCC_W + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request stream.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [bdqs_pkg::VALUE_W-1:0]  s_axis_tdata,  // [31:0] value
    input  wire logic [bdqs_pkg::REQ_W-1:0]    s_axis_tuser,  // [2:0] req_type
    // Result stream.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // From bit 0 up: status (2), found (1), occupancy (OCC_W), zero padding.
    output logic [OUT_DATA_W-1:0]              m_axis_tdata
);

    `include "bounded_deque_with_search_defines.svh"

    bdqs_pkg::t_cmd                w_cmd;
    bdqs_pkg::t_sts                w_sts;
    logic [bdqs_pkg::STATUS_W-1:0] w_status;
    logic                          w_found;
    logic [OCC_W-1:0]              w_occ;

    // The controller sequences requests and the search walk.
    bdqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the ring memory, the pointers and the result register.
    bdqs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (w_status),
        .o_found     (w_found),
        .o_occ       (w_occ)
    );

    // Fields are packed from bit 0 up and zero-extended to whole bytes.
    assign m_axis_tdata = OUT_DATA_W'({w_occ, w_found, w_status});

    // The occupancy reported can never exceed the capacity of the ring.
    `BDQS_ASSERT_SAME(a_occ_bound, m_axis_tvalid, (w_occ <= OCC_W'(DEPTH)),
        "occupancy above DEPTH")

    // A request is never taken while a stalled result still holds the register.
    `BDQS_ASSERT_SAME(a_no_overrun, (m_axis_tvalid && !m_axis_tready), !s_axis_tready,
        "request accepted while result is stalled")

    // Every request transfer other than a search gives a result in the next cycle.
    `BDQS_ASSERT_NEXT(a_fast_result,
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != bdqs_pkg::REQ_SEARCH)),
        m_axis_tvalid, "push or pop result missing")

    // Only a completed search may report a match.
    `BDQS_ASSERT_SAME(a_found_done, (m_axis_tvalid && w_found),
        (w_status == bdqs_pkg::ST_DONE), "found set with an error status")

endmodule

`default_nettype wire

// File: rtl/bdqs_ctrl.sv
// Controller state machine for the bounded deque with search.
`default_nettype none

module bdqs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire bdqs_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output bdqs_pkg::t_cmd     o_cmd
);

    bdqs_pkg::t_state r_state;
    bdqs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdqs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bdqs_pkg::S_IDLE: begin
                // A new request is taken only when its result has room.
                o_in_ready   = i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.is_search && !i_sts.empty) begin
                    n_state = bdqs_pkg::S_SEARCH;
                end
            end
            bdqs_pkg::S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.search_done) begin
                    n_state = bdqs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdqs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bdqs_dpath.sv
// Datapath of the bounded deque: ring memory, pointers, search walk, result register.
`default_nettype none

module bdqs_dpath #(
    parameter  int DEPTH = bdqs_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bdqs_pkg::t_cmd                i_cmd,
    output bdqs_pkg::t_sts                     o_sts,
    input  wire logic [bdqs_pkg::REQ_W-1:0]    i_req,
    input  wire logic [bdqs_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [bdqs_pkg::STATUS_W-1:0]      o_status,
    output logic                               o_found,
    output logic [CNT_W-1:0]                   o_occ
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);

    logic [bdqs_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]              r_front, n_front;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [bdqs_pkg::VALUE_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]              r_walk_ptr, n_walk_ptr;
    logic [CNT_W-1:0]              r_walk_left, n_walk_left;
    logic [bdqs_pkg::VALUE_W-1:0]  r_rd_data;
    logic                          r_rd_valid, n_rd_valid;
    logic                          r_out_valid, n_out_valid;
    logic [bdqs_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic                          r_out_found, n_out_found;
    logic [CNT_W-1:0]              r_out_occ, n_out_occ;

    logic                          w_wr_en;
    logic [IDX_W-1:0]              w_wr_addr;
    logic [IDX_W-1:0]              w_front_dec;
    logic [IDX_W-1:0]              w_front_inc;
    logic [IDX_W-1:0]              w_walk_inc;
    logic [CNT_W:0]                w_back_sum;
    logic [IDX_W-1:0]              w_back_pos;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_hit;
    logic                          w_search_done;

    // Ring arithmetic: pointers stay below DEPTH and the count at most DEPTH, so one compare wraps it.
    assign w_front_dec = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign w_front_inc = (r_front == LAST_IDX) ? '0 : r_front + IDX_W'(1);
    assign w_walk_inc  = (r_walk_ptr == LAST_IDX) ? '0 : r_walk_ptr + IDX_W'(1);
    assign w_back_sum  = (CNT_W + 1)'(r_front) + (CNT_W + 1)'(r_count);
    assign w_back_pos  = (w_back_sum >= DEPTH_SUM) ? IDX_W'(w_back_sum - DEPTH_SUM)
                                                   : IDX_W'(w_back_sum);

    assign w_full        = (r_count == DEPTH_CNT);
    assign w_empty       = (r_count == '0);
    assign w_hit         = r_rd_valid && (r_rd_data == r_key);
    assign w_search_done = r_rd_valid && (w_hit || (r_walk_left == '0));

    assign o_sts.is_search   = (i_req == bdqs_pkg::REQ_SEARCH);
    assign o_sts.empty       = w_empty;
    assign o_sts.search_done = w_search_done;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_key        = r_key;
        n_walk_ptr   = r_walk_ptr;
        n_walk_left  = r_walk_left;
        n_rd_valid   = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_occ    = r_out_occ;
        w_wr_en      = 1'b0;
        w_wr_addr    = w_front_dec;

        if (i_cmd.accept) begin
            n_out_valid  = 1'b1;
            n_out_status = bdqs_pkg::ST_DONE;
            n_out_found  = 1'b0;
            n_key        = i_value;
            n_walk_ptr   = r_front;
            n_walk_left  = r_count;
            case (i_req)
                bdqs_pkg::REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        n_out_status = bdqs_pkg::ST_FULL;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_front_dec;
                        n_front   = w_front_dec;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                bdqs_pkg::REQ_PUSH_BACK: begin
                    if (w_full) begin
                        n_out_status = bdqs_pkg::ST_FULL;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_back_pos;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                bdqs_pkg::REQ_POP_FRONT: begin
                    if (w_empty) begin
                        n_out_status = bdqs_pkg::ST_EMPTY;
                    end else begin
                        n_front = w_front_inc;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                bdqs_pkg::REQ_POP_BACK: begin
                    if (w_empty) begin
                        n_out_status = bdqs_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                bdqs_pkg::REQ_SEARCH: begin
                    // An empty sequence answers at once; otherwise the walk answers.
                    n_out_valid = w_empty;
                end
                default: begin
                end
            endcase
            n_out_occ = n_count;
        end else if (i_cmd.step) begin
            if (r_walk_left != '0) begin
                n_rd_valid  = 1'b1;
                n_walk_ptr  = w_walk_inc;
                n_walk_left = r_walk_left - CNT_W'(1);
            end
            if (w_search_done) begin
                n_out_valid  = 1'b1;
                n_out_status = bdqs_pkg::ST_DONE;
                n_out_found  = w_hit;
                n_out_occ    = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_walk_left <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_count     <= n_count;
            r_walk_left <= n_walk_left;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_walk_ptr   <= n_walk_ptr;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_occ    <= n_out_occ;
    end

    // Ring memory: one write port, one registered read port for the walk.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_value;
        end
        r_rd_data <= mem[r_walk_ptr];
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_occ       = r_out_occ;

endmodule

`default_nettype wire
